>>> rtl/dlq_pkg.sv
// Shared types and codes for the delta-list timer queue.
package dlq_pkg;

  // Input action codes.
  localparam logic [1:0] ACT_DELAY = 2'd0;
  localparam logic [1:0] ACT_TIME  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Result kind codes as they appear on the output.
  typedef enum logic [1:0] {
    KIND_WAKE   = 2'd0,
    KIND_TIME   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_WR,
    ST_EMIT_REJ,
    ST_EMIT_TIME,
    ST_TK_RD,
    ST_TK_CMP,
    ST_TK_NEXT,
    ST_EMIT_WAKE
  } state_e;

  // Which list position the memory read port looks at.
  typedef enum logic [1:0] {
    RD_POS,
    RD_SHIFT,
    RD_HEAD
  } rd_sel_e;

  // What the memory write port stores.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_NEW,
    WR_HEAD_DEC
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    tick_inc;
    logic    rd_en;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    walk_step;
    logic    fix_latch;
    logic    ctr_dec;
    logic    count_inc;
    logic    pop;
    logic    pend_load;
    logic    emit;
    kind_e   emit_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_at_end;
    logic wait_gt;
    logic head_gt1;
    logic ctr_at_pos;
    logic wake_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/dlq_ctrl.sv
// Sequencing state machine for the delta-list timer queue.
module dlq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_action_i,
  input  dlq_pkg::status_t status_i,
  output dlq_pkg::cmd_t    cmd_o,
  output logic             in_stall_o
);

  dlq_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          priority case (in_action_i)
            dlq_pkg::ACT_DELAY: begin
              state_d = status_i.full ? dlq_pkg::ST_EMIT_REJ : dlq_pkg::ST_INS_RD;
            end
            dlq_pkg::ACT_TIME: state_d = dlq_pkg::ST_EMIT_TIME;
            dlq_pkg::ACT_TICK: begin
              state_d = status_i.empty ? dlq_pkg::ST_IDLE : dlq_pkg::ST_TK_RD;
            end
            default: state_d = dlq_pkg::ST_IDLE;
          endcase
        end
      end
      dlq_pkg::ST_INS_RD: begin
        state_d = status_i.pos_at_end ? dlq_pkg::ST_SH_RD : dlq_pkg::ST_INS_CMP;
      end
      dlq_pkg::ST_INS_CMP: begin
        state_d = status_i.wait_gt ? dlq_pkg::ST_INS_RD : dlq_pkg::ST_SH_RD;
      end
      dlq_pkg::ST_SH_RD: begin
        state_d = status_i.ctr_at_pos ? dlq_pkg::ST_INS_WR : dlq_pkg::ST_SH_WR;
      end
      dlq_pkg::ST_SH_WR:  state_d = dlq_pkg::ST_SH_RD;
      dlq_pkg::ST_INS_WR: state_d = dlq_pkg::ST_IDLE;
      dlq_pkg::ST_EMIT_REJ, dlq_pkg::ST_EMIT_TIME: begin
        if (status_i.out_free) state_d = dlq_pkg::ST_IDLE;
      end
      dlq_pkg::ST_TK_RD: state_d = dlq_pkg::ST_TK_CMP;
      dlq_pkg::ST_TK_CMP: begin
        state_d = status_i.head_gt1 ? dlq_pkg::ST_IDLE : dlq_pkg::ST_TK_NEXT;
      end
      dlq_pkg::ST_TK_NEXT: state_d = dlq_pkg::ST_EMIT_WAKE;
      dlq_pkg::ST_EMIT_WAKE: begin
        if (status_i.out_free) begin
          state_d = status_i.wake_last ? dlq_pkg::ST_IDLE : dlq_pkg::ST_TK_NEXT;
        end
      end
      default: state_d = dlq_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o           = '0;
    cmd_o.rd_sel    = dlq_pkg::RD_POS;
    cmd_o.wr_sel    = dlq_pkg::WR_NONE;
    cmd_o.emit_kind = dlq_pkg::KIND_WAKE;
    in_stall_o      = (state_q != dlq_pkg::ST_IDLE);
    unique case (state_q)
      dlq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept   = 1'b1;
          cmd_o.tick_inc = (in_action_i == dlq_pkg::ACT_TICK);
        end
      end
      dlq_pkg::ST_INS_RD: begin
        cmd_o.rd_en  = !status_i.pos_at_end;
        cmd_o.rd_sel = dlq_pkg::RD_POS;
      end
      dlq_pkg::ST_INS_CMP: begin
        cmd_o.walk_step = status_i.wait_gt;
        cmd_o.fix_latch = !status_i.wait_gt;
      end
      dlq_pkg::ST_SH_RD: begin
        cmd_o.rd_en  = !status_i.ctr_at_pos;
        cmd_o.rd_sel = dlq_pkg::RD_SHIFT;
      end
      dlq_pkg::ST_SH_WR: begin
        cmd_o.wr_sel  = dlq_pkg::WR_SHIFT;
        cmd_o.ctr_dec = 1'b1;
      end
      dlq_pkg::ST_INS_WR: begin
        cmd_o.wr_sel    = dlq_pkg::WR_NEW;
        cmd_o.count_inc = 1'b1;
      end
      dlq_pkg::ST_EMIT_REJ: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_kind = dlq_pkg::KIND_REJECT;
      end
      dlq_pkg::ST_EMIT_TIME: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_kind = dlq_pkg::KIND_TIME;
      end
      dlq_pkg::ST_TK_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = dlq_pkg::RD_HEAD;
      end
      dlq_pkg::ST_TK_CMP: begin
        if (status_i.head_gt1) begin
          cmd_o.wr_sel = dlq_pkg::WR_HEAD_DEC;
        end else begin
          cmd_o.pend_load = 1'b1;
          cmd_o.pop       = 1'b1;
        end
      end
      dlq_pkg::ST_TK_NEXT: begin
        cmd_o.rd_en  = !status_i.empty;
        cmd_o.rd_sel = dlq_pkg::RD_HEAD;
      end
      dlq_pkg::ST_EMIT_WAKE: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_kind = dlq_pkg::KIND_WAKE;
        cmd_o.pend_load = status_i.out_free && !status_i.wake_last;
        cmd_o.pop       = status_i.out_free && !status_i.wake_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> rtl/dlq_dpath.sv
// Datapath: list memory, tick counter, insertion registers and result register.
module dlq_dpath #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dlq_pkg::cmd_t           cmd_i,
  output dlq_pkg::status_t        status_o,
  input  logic [TASK_ID_BITS-1:0] in_task_id_i,
  input  logic [31:0]             in_ticks_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              out_kind_o,
  output logic [TASK_ID_BITS-1:0] out_target_task_o,
  output logic [31:0]             out_time_value_o,
  output logic                    out_last_o
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // List storage, kept as a ring that starts at the head pointer.
  logic [TASK_ID_BITS-1:0] mem_task  [QUEUE_DEPTH];
  logic [31:0]             mem_delta [QUEUE_DEPTH];

  logic [IW-1:0]           head_q;
  logic [CW-1:0]           count_q;
  logic [31:0]             tick_q;
  logic [CW-1:0]           pos_q;
  logic [CW-1:0]           ctr_q;
  logic [31:0]             wait_q;
  logic [31:0]             succ_q;
  logic [TASK_ID_BITS-1:0] task_q;
  logic [TASK_ID_BITS-1:0] pend_q;
  logic [TASK_ID_BITS-1:0] rtask_q;
  logic [31:0]             rdelta_q;

  logic                    out_valid_q;
  logic [1:0]              out_kind_q;
  logic [TASK_ID_BITS-1:0] out_task_q;
  logic [31:0]             out_time_q;
  logic                    out_last_q;

  logic [CW-1:0]           rd_lidx;
  logic [CW-1:0]           wr_lidx;
  logic                    wr_en;
  logic [TASK_ID_BITS-1:0] wr_task;
  logic [31:0]             wr_delta;
  logic                    shift_fix;
  logic                    out_free;
  logic                    wake_last;

  // Map a position in the list to a ring address.
  function automatic logic [IW-1:0] phys_idx(logic [IW-1:0] head, logic [CW-1:0] lidx);
    logic [IW:0] sum;
    sum = {1'b0, head} + (IW+1)'(lidx);
    if (sum >= (IW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IW+1)'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  // Read position select.
  always_comb begin
    unique case (cmd_i.rd_sel)
      dlq_pkg::RD_POS:   rd_lidx = pos_q;
      dlq_pkg::RD_SHIFT: rd_lidx = ctr_q - CW'(1);
      dlq_pkg::RD_HEAD:  rd_lidx = '0;
      default:           rd_lidx = '0;
    endcase
  end

  // The entry right behind the new one loses the new entry's wait.
  assign shift_fix = (ctr_q == pos_q + CW'(1));

  // Write position and data select.
  always_comb begin
    wr_en    = 1'b1;
    wr_lidx  = '0;
    wr_task  = rtask_q;
    wr_delta = rdelta_q;
    unique case (cmd_i.wr_sel)
      dlq_pkg::WR_NONE: wr_en = 1'b0;
      dlq_pkg::WR_SHIFT: begin
        wr_lidx  = ctr_q;
        wr_delta = shift_fix ? succ_q : rdelta_q;
      end
      dlq_pkg::WR_NEW: begin
        wr_lidx  = pos_q;
        wr_task  = task_q;
        wr_delta = wait_q;
      end
      dlq_pkg::WR_HEAD_DEC: wr_delta = rdelta_q - 32'd1;
      default: wr_en = 1'b0;
    endcase
  end

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_task[phys_idx(head_q, wr_lidx)]  <= wr_task;
      mem_delta[phys_idx(head_q, wr_lidx)] <= wr_delta;
    end
    if (cmd_i.rd_en) begin
      rtask_q  <= mem_task[phys_idx(head_q, rd_lidx)];
      rdelta_q <= mem_delta[phys_idx(head_q, rd_lidx)];
    end
  end

  // List bookkeeping and tick counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      tick_q  <= '0;
    end else begin
      if (cmd_i.tick_inc) tick_q <= tick_q + 32'd1;
      if (cmd_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.pop) begin
        count_q <= count_q - CW'(1);
        head_q  <= (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IW'(1);
      end
    end
  end

  // Insertion walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      task_q <= in_task_id_i;
      wait_q <= in_ticks_i;
      pos_q  <= '0;
      ctr_q  <= count_q;
    end else begin
      if (cmd_i.walk_step) begin
        wait_q <= wait_q - rdelta_q;
        pos_q  <= pos_q + CW'(1);
      end
      if (cmd_i.ctr_dec) ctr_q <= ctr_q - CW'(1);
    end
    if (cmd_i.fix_latch) succ_q <= rdelta_q - wait_q;
    if (cmd_i.pend_load) pend_q <= rtask_q;
  end

  // A wake is the last one when the list has run dry or the new head still waits.
  assign wake_last = (count_q == '0) || (rdelta_q != 32'd0);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.emit_kind;
      unique case (cmd_i.emit_kind)
        dlq_pkg::KIND_TIME: begin
          out_task_q <= task_q;
          out_time_q <= tick_q;
          out_last_q <= 1'b1;
        end
        dlq_pkg::KIND_REJECT: begin
          out_task_q <= task_q;
          out_time_q <= '0;
          out_last_q <= 1'b1;
        end
        default: begin
          out_task_q <= pend_q;
          out_time_q <= '0;
          out_last_q <= wake_last;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_kind_q;
  assign out_target_task_o = out_task_q;
  assign out_time_value_o  = out_time_q;
  assign out_last_o        = out_last_q;

  // Status to the controller.
  assign status_o.full       = (count_q == CW'(QUEUE_DEPTH));
  assign status_o.empty      = (count_q == '0);
  assign status_o.pos_at_end = (pos_q == count_q);
  assign status_o.wait_gt    = (wait_q > rdelta_q);
  assign status_o.head_gt1   = (rdelta_q > 32'd1);
  assign status_o.ctr_at_pos = (ctr_q == pos_q);
  assign status_o.wake_last  = wake_last;
  assign status_o.out_free   = out_free;

endmodule

>>> rtl/delta_list_timer_queue_core.sv
// Top level of the delta-list timer queue: controller plus datapath.
//
// The block keeps a 32-bit wrapping tick counter and a sorted list of up to
// QUEUE_DEPTH waiting tasks, each stored as its wait relative to the entry
// ahead of it, in a single-port-read, single-port-write memory used as a ring.
// One item is worked on at a time. A get-time request or a rejected delay
// goes straight to the result register, plus any wait for it to be free.
// An accepted delay walks past the entries whose wait is smaller than its
// remaining wait, then moves each entry behind its place back one place and
// writes the new entry; each step costs a memory read and a compare or a
// write. A tick on an empty list only advances the counter; otherwise it
// reads the head and either decrements its wait or wakes it and each next
// head with no wait left, reading each new head before its wake is emitted.
// The list starts empty at reset and needs no clearing pass.
module delta_list_timer_queue_core #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              in_action_i,
  input  logic [TASK_ID_BITS-1:0] in_task_id_i,
  input  logic [31:0]             in_ticks_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              out_kind_o,
  output logic [TASK_ID_BITS-1:0] out_target_task_o,
  output logic [31:0]             out_time_value_o,
  output logic                    out_last_o
);

  dlq_pkg::cmd_t    cmd;
  dlq_pkg::status_t status;

  // Sequencer.
  dlq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_action_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  // Storage and arithmetic.
  dlq_dpath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .in_task_id_i      (in_task_id_i),
    .in_ticks_i        (in_ticks_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_kind_o        (out_kind_o),
    .out_target_task_o (out_target_task_o),
    .out_time_value_o  (out_time_value_o),
    .out_last_o        (out_last_o)
  );

endmodule

>>> rtl/dlq_checker.sv
// Port-level checks for the delta-list timer queue, bound to the top level.
module dlq_checker #(
  parameter int TASK_ID_BITS = 8
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [1:0]              out_kind_o,
  input logic [TASK_ID_BITS-1:0] out_target_task_o,
  input logic [31:0]             out_time_value_o,
  input logic                    out_last_o
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o) &&
    $stable(out_target_task_o) && $stable(out_time_value_o) && $stable(out_last_o))
    else $error("stalled result changed");

  // Only defined result kinds are shown.
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kind_o == dlq_pkg::KIND_WAKE) ||
    (out_kind_o == dlq_pkg::KIND_TIME) || (out_kind_o == dlq_pkg::KIND_REJECT))
    else $error("unknown result kind");

  // Time replies and rejects are single results.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_kind_o == dlq_pkg::KIND_TIME) ||
    (out_kind_o == dlq_pkg::KIND_REJECT)) |-> out_last_o)
    else $error("time reply or reject without last");

  // Only time replies carry a time value.
  a_time_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o != dlq_pkg::KIND_TIME) |-> (out_time_value_o == 32'd0))
    else $error("nonzero time value outside a time reply");

endmodule

bind delta_list_timer_queue_core dlq_checker #(
  .TASK_ID_BITS (TASK_ID_BITS)
) u_dlq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .out_kind_o        (out_kind_o),
  .out_target_task_o (out_target_task_o),
  .out_time_value_o  (out_time_value_o),
  .out_last_o        (out_last_o)
);

>>> tb/delta_list_timer_queue_core_test.sv
// Self-checking testbench for the delta-list timer queue core.
module delta_list_timer_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 16;
  localparam int TASK_BITS = 8;
  localparam int MAX_IDLE  = 18;
  localparam int RAND_ITEMS = 96;
  localparam int TAIL_CYCLES = 60;
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;

  // Action code 3 has no meaning and is dropped by the block.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One result as it leaves the block.
  typedef struct packed {
    dlq_pkg::kind_e        kind;
    logic [TASK_BITS-1:0]  target;
    logic [31:0]           stamp;
    logic                  last;
  } outcome_t;

  // One directed row: the request, and an optional result typed in by hand.
  typedef struct packed {
    logic [1:0]            act;
    logic [TASK_BITS-1:0]  tid;
    logic [31:0]           dly;
    logic                  typed;
    outcome_t              want;
  } stim_row_t;

  localparam outcome_t NO_CHECK = '{dlq_pkg::KIND_WAKE, 8'h00, 32'h0, 1'b0};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           in_action_i;
  logic [TASK_BITS-1:0] in_task_id_i;
  logic [31:0]          in_ticks_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           out_kind_o;
  logic [TASK_BITS-1:0] out_target_task_o;
  logic [31:0]          out_time_value_o;
  logic                 out_last_o;

  // Shadow copy of the delta list and the tick counter.
  logic [TASK_BITS-1:0] sleeper_task [DEPTH];
  logic [31:0]          sleeper_delta [DEPTH];
  int unsigned          sleeper_count;
  logic [31:0]          tick_now;

  outcome_t  step_out[$];
  outcome_t  awaited_q[$];
  stim_row_t plan[$];
  int        fail_count;
  bit        calm;

  delta_list_timer_queue_core #(
    .QUEUE_DEPTH (DEPTH),
    .TASK_ID_BITS(TASK_BITS)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_action_i      (in_action_i),
    .in_task_id_i     (in_task_id_i),
    .in_ticks_i       (in_ticks_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_kind_o       (out_kind_o),
    .out_target_task_o(out_target_task_o),
    .out_time_value_o (out_time_value_o),
    .out_last_o       (out_last_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("delta_list_timer_queue_core_test NOT OK");
    $finish;
  end

  // Idle cycles before the next transfer; none during calm stretches.
  function automatic int pick_gap();
    if (calm) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  // Drop the head entry and close up the list.
  function automatic void drop_head();
    int unsigned i;
    for (i = 1; i < sleeper_count; i++) begin
      sleeper_task[i-1]  = sleeper_task[i];
      sleeper_delta[i-1] = sleeper_delta[i];
    end
    sleeper_count--;
  endfunction

  // Works out the results of one request and updates the shadow list.
  function automatic void timer_queue_step(input logic [1:0] act,
                                           input logic [TASK_BITS-1:0] tid,
                                           input logic [31:0] dly);
    outcome_t    r;
    int unsigned pos;
    int unsigned i;
    logic [31:0] rem;
    bit          more;
    step_out.delete();
    case (act)
      dlq_pkg::ACT_DELAY: begin
        if (sleeper_count >= DEPTH) begin
          r = '{dlq_pkg::KIND_REJECT, tid, 32'h0, 1'b1};
          step_out.push_back(r);
        end else begin
          // Walk past every entry whose running total is strictly smaller.
          pos = 0;
          rem = dly;
          while (pos < sleeper_count && rem > sleeper_delta[pos]) begin
            rem -= sleeper_delta[pos];
            pos++;
          end
          for (i = sleeper_count; i > pos; i--) begin
            sleeper_task[i]  = sleeper_task[i-1];
            sleeper_delta[i] = sleeper_delta[i-1];
          end
          sleeper_task[pos]  = tid;
          sleeper_delta[pos] = rem;
          if (pos < sleeper_count) sleeper_delta[pos+1] -= rem;
          sleeper_count++;
        end
      end
      dlq_pkg::ACT_TIME: begin
        r = '{dlq_pkg::KIND_TIME, tid, tick_now, 1'b1};
        step_out.push_back(r);
      end
      dlq_pkg::ACT_TICK: begin
        tick_now += 32'd1;
        if (sleeper_count != 0) begin
          if (sleeper_delta[0] > 32'd1) begin
            sleeper_delta[0] -= 32'd1;
          end else begin
            // The head wakes, then every following head with no difference left.
            do begin
              r.kind   = dlq_pkg::KIND_WAKE;
              r.target = sleeper_task[0];
              r.stamp  = 32'h0;
              drop_head();
              more   = (sleeper_count != 0) && (sleeper_delta[0] == 32'd0);
              r.last = !more;
              step_out.push_back(r);
            end while (more);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Presents one request, waits for its transfer and books its results.
  task automatic send_item(input logic [1:0] act, input logic [TASK_BITS-1:0] tid,
                           input logic [31:0] dly, input logic typed,
                           input outcome_t want);
    int gap;
    bit stalled;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_action_i  <= act;
    in_task_id_i <= tid;
    in_ticks_i   <= dly;
    // Stall is read mid-cycle, where it holds the value the next edge sees.
    do begin
      @(negedge clk_i);
      stalled = (in_stall_o !== 1'b0);
      @(posedge clk_i);
    end while (stalled);
    timer_queue_step(act, tid, dly);
    if (typed) begin
      awaited_q.push_back(want);
    end else begin
      foreach (step_out[j]) awaited_q.push_back(step_out[j]);
    end
  endtask

  // Result side: random stall, then compare each transfer with the oldest expectation.
  initial begin
    int                   hold;
    outcome_t             want;
    bit                   seen;
    logic [1:0]           got_kind;
    logic [TASK_BITS-1:0] got_task;
    logic [31:0]          got_time;
    logic                 got_last;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      // The result is captured mid-cycle, ahead of the edge that takes it.
      do begin
        @(negedge clk_i);
        seen     = (out_valid_o === 1'b1);
        got_kind = out_kind_o;
        got_task = out_target_task_o;
        got_time = out_time_value_o;
        got_last = out_last_o;
        @(posedge clk_i);
      end while (!seen);
      if (awaited_q.size() == 0) begin
        $error("unexpected result: kind %0d task %0d time %0d last %0d",
               got_kind, got_task, got_time, got_last);
        fail_count++;
      end else begin
        want = awaited_q.pop_front();
        if (got_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got_kind);
          fail_count++;
        end
        if (got_task !== want.target) begin
          $error("target_task: expected %0d, got %0d", want.target, got_task);
          fail_count++;
        end
        if (got_time !== want.stamp) begin
          $error("time_value: expected %0d, got %0d", want.stamp, got_time);
          fail_count++;
        end
        if (got_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got_last);
          fail_count++;
        end
      end
    end
  end

  // Reset, directed table, random traffic, drain and verdict.
  initial begin
    int          k;
    int          sent;
    int          phase;
    int          delay_pct;
    int          r;
    int          s;
    logic [1:0]  act;
    logic [TASK_BITS-1:0] tid;
    logic [31:0] dly;

    fail_count    = 0;
    calm          = 1'b0;
    sleeper_count = 0;
    tick_now      = 32'h0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_action_i   = dlq_pkg::ACT_DELAY;
    in_task_id_i  = '0;
    in_ticks_i    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Counter reads zero after reset; a tick on an empty list says nothing.
    plan.push_back('{dlq_pkg::ACT_TIME, 8'h00, 32'h0, 1'b1,
                     '{dlq_pkg::KIND_TIME, 8'h00, 32'h0, 1'b1}});
    plan.push_back('{dlq_pkg::ACT_TICK, 8'h00, 32'h0, 1'b0, NO_CHECK});
    // A delay of zero wakes on the very next tick.
    plan.push_back('{dlq_pkg::ACT_DELAY, 8'hFF, 32'h0, 1'b0, NO_CHECK});
    plan.push_back('{dlq_pkg::ACT_TICK, 8'h00, 32'h0, 1'b0, NO_CHECK});
    // The unused action code is dropped without a trace.
    plan.push_back('{ACT_UNUSED, 8'h5A, 32'h1234_5678, 1'b0, NO_CHECK});
    // Longest possible wait goes to the tail and never wakes during the run.
    plan.push_back('{dlq_pkg::ACT_DELAY, 8'h00, 32'hFFFF_FFFF, 1'b0, NO_CHECK});
    // Fill the list with short, often equal waits.
    for (k = 0; k < DEPTH - 1; k++) begin
      plan.push_back('{dlq_pkg::ACT_DELAY, 8'(32 + 13 * k), 32'(k % 4), 1'b0, NO_CHECK});
    end
    // A full list turns a delay into a reject.
    plan.push_back('{dlq_pkg::ACT_DELAY, 8'hAA, 32'h7, 1'b1,
                     '{dlq_pkg::KIND_REJECT, 8'hAA, 32'h0, 1'b1}});
    // Zero-difference group wakes together, then the group waiting one tick.
    plan.push_back('{dlq_pkg::ACT_TICK, 8'h00, 32'h0, 1'b0, NO_CHECK});
    plan.push_back('{dlq_pkg::ACT_TICK, 8'h00, 32'h0, 1'b0, NO_CHECK});
    plan.push_back('{dlq_pkg::ACT_TIME, 8'h3C, 32'h0, 1'b0, NO_CHECK});

    foreach (plan[i]) begin
      send_item(plan[i].act, plan[i].tid, plan[i].dly, plan[i].typed, plan[i].want);
    end

    // Random traffic in phases: balanced, delay-heavy, tick-heavy, balanced.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      phase = sent / 30;
      calm  = (phase % 2) == 1;
      case (phase)
        1:       delay_pct = 70;
        2:       delay_pct = 20;
        default: delay_pct = 40;
      endcase
      r = $urandom_range(0, 99);
      if (r < delay_pct)   act = dlq_pkg::ACT_DELAY;
      else if (r < 85)     act = dlq_pkg::ACT_TICK;
      else if (r < 95)     act = dlq_pkg::ACT_TIME;
      else                 act = ACT_UNUSED;
      tid = 8'($urandom_range(0, 255));
      s = $urandom_range(0, 99);
      if (s < 80)          dly = $urandom_range(0, 12);
      else if (s < 95)     dly = $urandom_range(0, 60);
      else if (s < 98)     dly = $urandom;
      else                 dly = 32'hFFFF_FFFF;
      send_item(act, tid, dly, 1'b0, NO_CHECK);
      if (act != ACT_UNUSED) sent++;
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    // Drain outstanding results, then watch for strays.
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("delta_list_timer_queue_core_test OK");
    end else begin
      $display("delta_list_timer_queue_core_test NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dlq_pkg.sv
rtl/dlq_ctrl.sv
rtl/dlq_dpath.sv
rtl/delta_list_timer_queue_core.sv
rtl/dlq_checker.sv
tb/delta_list_timer_queue_core_test.sv
